/* rtl/core/tem_pkg.sv */
// shared constants for the thruster effort mixer
// no dependencies; imported by thruster_effort_mixer

package tem_pkg;

    // default width of one effort or command field
    localparam int EFFORT_WIDTH_DEF = 16;

    // number of thruster commands per word
    localparam int NUM_LANES = 8;

    // number of effort fields per input word
    localparam int NUM_EFFORTS = 6;

    // 45 degree rotation coefficient 0.7071 in Q1.15
    localparam logic signed [15:0] ROT_COEF = 16'sd23170;
    localparam int ROT_SHIFT = 15;

    // fraction bits of the Q4.12 format
    localparam int FRAC_BITS = 12;

endpackage

/* rtl/core/thruster_effort_mixer.sv */
// thruster effort mixer: six efforts in, eight normalized thruster commands out
// depends on tem_pkg for field counts and fixed-point constants
//
//   port group   dir  payload (lowest bits first)                        accepted when
//   i_s_*        in   surge, sway, heave, roll, pitch, yaw (each W)      i_s_tvalid & o_s_tready
//   o_m_*        out  hfl, hfr, vfl, vfr, hbl, hbr, vbl, vbr (each W)    o_m_tvalid & i_m_tready
//
// one word enters per clock while the output side keeps accepting; the depth is set by the
// restoring divider that spends one register stage per quotient bit (W + 1 bits)
// reset clears only the valid bits of all stages
// each stage advances when it is empty or the stage after it advances, so
// bubbles close up under a stall and nothing is dropped or repeated

module thruster_effort_mixer
    import tem_pkg::*;
#(
    parameter int EFFORT_WIDTH = EFFORT_WIDTH_DEF
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_s_tvalid,
    output logic                                    o_s_tready,
    // surge, sway, heave, roll, pitch, yaw; zero padded to whole bytes
    input  logic [((NUM_EFFORTS*EFFORT_WIDTH+7)/8)*8-1:0] i_s_tdata,
    output logic                                    o_m_tvalid,
    input  logic                                    i_m_tready,
    // hfl, hfr, vfl, vfr, hbl, hbr, vbl, vbr
    output logic [NUM_LANES*EFFORT_WIDTH-1:0]       o_m_tdata
);

    localparam int W   = EFFORT_WIDTH;
    localparam int SW  = W + 1;                 // sum of two efforts
    localparam int PW  = W + 17;                // rotation product
    localparam int RW  = W + 2;                 // raw mixed value, signed
    localparam int MW  = W + 1;                 // magnitude and peak, unsigned
    localparam int QB  = W + 1;                 // quotient bits computed
    localparam int NW  = MW + FRAC_BITS + 1;    // scaled numerator
    localparam int HW  = NW - QB;               // numerator bits above the quotient
    localparam int NS  = QB + 8;                // total register stages
    localparam int ST_DIV = 6;                  // stage holding the divider setup

    localparam logic signed [PW-1:0] RND_POS = PW'(1 << (ROT_SHIFT - 1));
    localparam logic signed [PW-1:0] RND_NEG = PW'((1 << (ROT_SHIFT - 1)) - 1);
    localparam logic [QB-1:0] Q_POS_LIM = QB'((64'd1 << (W - 1)) - 64'd1);
    localparam logic [QB-1:0] Q_NEG_LIM = QB'(64'd1 << (W - 1));
    localparam logic [W-1:0]  OUT_MAX   = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0]  OUT_MIN   = {1'b1, {(W-1){1'b0}}};

    // ---------------- flow control ----------------
    logic [NS-1:0] r_v;
    logic [NS-1:0] w_en;

    always_comb begin
        w_en[NS-1] = !r_v[NS-1] || i_m_tready;
        for (int k = NS - 2; k >= 0; k--) begin
            w_en[k] = !r_v[k] || w_en[k+1];
        end
    end

    assign o_s_tready = w_en[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_en[0]) begin
                r_v[0] <= i_s_tvalid;
            end
            for (int k = 1; k < NS; k++) begin
                if (w_en[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    // ---------------- stage 0: capture efforts ----------------
    logic signed [W-1:0] r_eff0 [0:NUM_EFFORTS-1];

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            for (int e = 0; e < NUM_EFFORTS; e++) begin
                r_eff0[e] <= i_s_tdata[e*W +: W];
            end
        end
    end

    // ---------------- stage 1: rotation products, vertical pairs ----------------
    logic signed [PW-1:0] r_pa1, r_pb1;
    logic signed [SW-1:0] r_hm1, r_hp1;
    logic signed [W-1:0]  r_roll1, r_yaw1;
    logic signed [SW-1:0] n_sa, n_sb;

    always_comb begin
        n_sa = SW'(r_eff0[0]) + SW'(r_eff0[1]);
        n_sb = SW'(r_eff0[0]) - SW'(r_eff0[1]);
    end

    always_ff @(posedge i_clk) begin
        if (w_en[1]) begin
            r_pa1   <= PW'(n_sa) * PW'(ROT_COEF);
            r_pb1   <= PW'(n_sb) * PW'(ROT_COEF);
            r_hm1   <= SW'(r_eff0[2]) - SW'(r_eff0[4]);
            r_hp1   <= SW'(r_eff0[2]) + SW'(r_eff0[4]);
            r_roll1 <= r_eff0[3];
            r_yaw1  <= r_eff0[5];
        end
    end

    // ---------------- stage 2: round rotation, vertical raw ----------------
    logic signed [RW-1:0] r_rota2, r_rotb2, r_yaw2;
    logic signed [RW-1:0] r_vert2 [0:3];
    logic signed [PW-1:0] n_ra, n_rb;

    // round to nearest, ties away from zero, as one add and a shift
    always_comb begin
        n_ra = r_pa1 + (r_pa1[PW-1] ? RND_NEG : RND_POS);
        n_rb = r_pb1 + (r_pb1[PW-1] ? RND_NEG : RND_POS);
    end

    always_ff @(posedge i_clk) begin
        if (w_en[2]) begin
            r_rota2    <= n_ra[ROT_SHIFT +: RW];
            r_rotb2    <= n_rb[ROT_SHIFT +: RW];
            r_yaw2     <= RW'(r_yaw1);
            r_vert2[0] <= RW'(r_hm1) + RW'(r_roll1);
            r_vert2[1] <= RW'(r_hm1) - RW'(r_roll1);
            r_vert2[2] <= RW'(r_hp1) + RW'(r_roll1);
            r_vert2[3] <= RW'(r_hp1) - RW'(r_roll1);
        end
    end

    // ---------------- stage 3: all eight raw values ----------------
    logic signed [RW-1:0] r_raw3 [0:NUM_LANES-1];

    always_ff @(posedge i_clk) begin
        if (w_en[3]) begin
            r_raw3[0] <= r_rotb2 - r_yaw2;
            r_raw3[1] <= r_rota2 + r_yaw2;
            r_raw3[2] <= r_vert2[0];
            r_raw3[3] <= r_vert2[1];
            r_raw3[4] <= r_rota2 - r_yaw2;
            r_raw3[5] <= r_rotb2 + r_yaw2;
            r_raw3[6] <= r_vert2[2];
            r_raw3[7] <= r_vert2[3];
        end
    end

    // ---------------- stage 4: pairwise maxima ----------------
    logic signed [RW-1:0] r_raw4  [0:NUM_LANES-1];
    logic signed [RW-1:0] r_pmax4 [0:NUM_LANES/2-1];

    always_ff @(posedge i_clk) begin
        if (w_en[4]) begin
            for (int i = 0; i < NUM_LANES; i++) begin
                r_raw4[i] <= r_raw3[i];
            end
            for (int i = 0; i < NUM_LANES / 2; i++) begin
                r_pmax4[i] <= (r_raw3[2*i] > r_raw3[2*i+1]) ? r_raw3[2*i] : r_raw3[2*i+1];
            end
        end
    end

    // ---------------- stage 5: peak, sign and magnitude ----------------
    logic [MW-1:0]           r_peak5;
    logic [MW-1:0]           r_mag5 [0:NUM_LANES-1];
    logic [NUM_LANES-1:0]    r_neg5;
    logic signed [RW-1:0]    n_m01, n_m23, n_mall;
    logic [RW-1:0]           n_negr [0:NUM_LANES-1];

    always_comb begin
        n_m01  = (r_pmax4[0] > r_pmax4[1]) ? r_pmax4[0] : r_pmax4[1];
        n_m23  = (r_pmax4[2] > r_pmax4[3]) ? r_pmax4[2] : r_pmax4[3];
        n_mall = (n_m01 > n_m23) ? n_m01 : n_m23;
        for (int i = 0; i < NUM_LANES; i++) begin
            n_negr[i] = RW'(0) - r_raw4[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[5]) begin
            // nothing positive leaves the peak at zero
            r_peak5 <= n_mall[RW-1] ? '0 : n_mall[MW-1:0];
            for (int i = 0; i < NUM_LANES; i++) begin
                r_neg5[i] <= r_raw4[i][RW-1];
                r_mag5[i] <= r_raw4[i][RW-1] ? n_negr[i][MW-1:0] : r_raw4[i][MW-1:0];
            end
        end
    end

    // ---------------- divider pipeline ----------------
    // index 0 is the setup stage, index j holds the state after quotient bit j
    logic [MW-1:0]        r_rem  [0:QB][0:NUM_LANES-1];
    logic [QB-1:0]        r_nq   [0:QB][0:NUM_LANES-1];
    logic [MW-1:0]        r_den  [0:QB];
    logic [NUM_LANES-1:0] r_neg  [0:QB];
    logic [NUM_LANES-1:0] r_ovf  [0:QB];
    logic                 r_zero [0:QB];

    logic [NW-1:0] n_num [0:NUM_LANES-1];
    logic [HW-1:0] n_hi  [0:NUM_LANES-1];

    // numerator = |raw| * 2^12 + floor(peak / 2); high part at or above the
    // peak means the quotient needs more than QB bits and saturates
    always_comb begin
        for (int i = 0; i < NUM_LANES; i++) begin
            n_num[i] = NW'({r_mag5[i], {FRAC_BITS{1'b0}}}) + NW'(r_peak5 >> 1);
            n_hi[i]  = n_num[i][NW-1:QB];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[ST_DIV]) begin
            r_den[0]  <= r_peak5;
            r_neg[0]  <= r_neg5;
            r_zero[0] <= (r_peak5 == '0);
            for (int i = 0; i < NUM_LANES; i++) begin
                r_ovf[0][i] <= (NW'(n_hi[i]) >= NW'(r_peak5));
                r_rem[0][i] <= MW'(n_hi[i]);
                r_nq[0][i]  <= n_num[i][QB-1:0];
            end
        end
    end

    for (genvar j = 1; j <= QB; j++) begin : g_div
        always_ff @(posedge i_clk) begin
            if (w_en[ST_DIV+j]) begin
                r_den[j]  <= r_den[j-1];
                r_neg[j]  <= r_neg[j-1];
                r_ovf[j]  <= r_ovf[j-1];
                r_zero[j] <= r_zero[j-1];
            end
        end

        for (genvar i = 0; i < NUM_LANES; i++) begin : g_lane
            logic [MW:0] n_t;
            logic [MW:0] n_diff;
            logic        n_ge;

            // shift in the next numerator bit, subtract when it fits
            assign n_t    = {r_rem[j-1][i], r_nq[j-1][i][QB-1]};
            assign n_diff = n_t - {1'b0, r_den[j-1]};
            assign n_ge   = (n_t >= {1'b0, r_den[j-1]});

            always_ff @(posedge i_clk) begin
                if (w_en[ST_DIV+j]) begin
                    r_rem[j][i] <= n_ge ? n_diff[MW-1:0] : n_t[MW-1:0];
                    r_nq[j][i]  <= {r_nq[j-1][i][QB-2:0], n_ge};
                end
            end
        end
    end

    // ---------------- output stage: sign and saturate ----------------
    logic [NUM_LANES*W-1:0] r_out;
    logic [W-1:0]           n_cmd [0:NUM_LANES-1];
    logic [QB-1:0]          n_negq [0:NUM_LANES-1];

    always_comb begin
        for (int i = 0; i < NUM_LANES; i++) begin
            n_negq[i] = ~r_nq[QB][i] + 1'b1;
            if (r_zero[QB]) begin
                n_cmd[i] = '0;
            end else if (r_neg[QB][i]) begin
                if (r_ovf[QB][i] || (r_nq[QB][i] > Q_NEG_LIM)) begin
                    n_cmd[i] = OUT_MIN;
                end else begin
                    n_cmd[i] = n_negq[i][W-1:0];
                end
            end else begin
                if (r_ovf[QB][i] || (r_nq[QB][i] > Q_POS_LIM)) begin
                    n_cmd[i] = OUT_MAX;
                end else begin
                    n_cmd[i] = r_nq[QB][i][W-1:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[NS-1]) begin
            for (int i = 0; i < NUM_LANES; i++) begin
                r_out[i*W +: W] <= n_cmd[i];
            end
        end
    end

    assign o_m_tvalid = r_v[NS-1];
    assign o_m_tdata  = r_out;

`ifndef SYNTHESIS
    logic [NUM_LANES-1:0] a_rem_ok0;
    logic [NUM_LANES-1:0] a_rem_okn;
    logic [NUM_LANES-1:0] a_nonpos5;

    always_comb begin
        for (int i = 0; i < NUM_LANES; i++) begin
            a_rem_ok0[i] = r_ovf[0][i] || r_zero[0] || (r_rem[0][i] < r_den[0]);
            a_rem_okn[i] = r_ovf[QB][i] || r_zero[QB] || (r_rem[QB][i] < r_den[QB]);
            a_nonpos5[i] = r_neg5[i] || (r_mag5[i] == '0);
        end
    end

    // an empty output register always lets a new word in
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_tvalid |-> o_s_tready)
        else $error("input stalled with an empty output stage");

    // the partial remainder stays below the divisor through the divider
    a_rem_setup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[ST_DIV] |-> (&a_rem_ok0))
        else $error("divider setup remainder not below peak");

    a_rem_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[NS-2] |-> (&a_rem_okn))
        else $error("divider remainder not below peak");

    // a zero peak only when no lane is positive
    a_zero_peak: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v[5] && (r_peak5 == '0)) |-> (&a_nonpos5))
        else $error("peak is zero while a lane is positive");

    // a result appears only behind a word in the last divider stage
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_tvalid) |-> $past(r_v[NS-2]))
        else $error("result word without a source");
`endif

endmodule

/* bench/tb_thruster_effort_mixer.sv */
`timescale 1ns / 100ps
// testbench for thruster_effort_mixer: directed and random effort words, each
// result checked lane by lane against a fixed-point mixing predictor
// depends on tem_pkg and the thruster_effort_mixer rtl

module tb_thruster_effort_mixer
    import tem_pkg::*;
();

    localparam int W = EFFORT_WIDTH_DEF;
    localparam int IN_BITS = ((NUM_EFFORTS * W + 7) / 8) * 8;
    localparam int OUT_BITS = NUM_LANES * W;
    localparam int LATENCY = W + 9;
    localparam int CYCLE_LIMIT = 400000;
    localparam longint FIELD_MAX = (longint'(1) << (W - 1)) - 1;
    localparam longint FIELD_MIN = -FIELD_MAX - 1;

    typedef enum int {SURGE, SWAY, HEAVE, ROLL, PITCH, YAW} t_effort;
    typedef enum int {HFL, HFR, VFL, VFR, HBL, HBR, VBL, VBR} t_lane;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [IN_BITS-1:0]  s_tdata = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [OUT_BITS-1:0] m_tdata;

    logic [OUT_BITS-1:0] expected_cmds [$];
    string lane_names [NUM_LANES] = '{"hfl", "hfr", "vfl", "vfr", "hbl", "hbr", "vbl", "vbr"};
    int src_idle_pct = 0;
    int snk_idle_pct = 0;
    int mismatch_count = 0;
    int sent_count = 0;
    int recv_count = 0;
    int cycle_count = 0;

    thruster_effort_mixer #(.EFFORT_WIDTH(W)) dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata)
    );

    always #10 clk = ~clk;

    // rounds to nearest, ties away from zero; den is positive
    function automatic longint round_div(input longint num, input longint den);
        longint mag;
        longint q;
        mag = (num < 0) ? -num : num;
        q = (mag + den / 2) / den;
        return (num < 0) ? -q : q;
    endfunction

    function automatic logic [OUT_BITS-1:0] mix_commands(input logic [IN_BITS-1:0] word);
        longint eff [NUM_EFFORTS];
        longint raw [NUM_LANES];
        longint rot_a;
        longint rot_b;
        longint peak;
        longint q;
        logic [OUT_BITS-1:0] cmds;
        for (int i = 0; i < NUM_EFFORTS; i++)
            eff[i] = longint'($signed(word[i*W +: W]));
        rot_a = round_div(longint'(ROT_COEF) * (eff[SURGE] + eff[SWAY]), longint'(1) << ROT_SHIFT);
        rot_b = round_div(longint'(ROT_COEF) * (eff[SURGE] - eff[SWAY]), longint'(1) << ROT_SHIFT);
        raw[HFL] = rot_b - eff[YAW];
        raw[HFR] = rot_a + eff[YAW];
        raw[VFL] = eff[HEAVE] - eff[PITCH] + eff[ROLL];
        raw[VFR] = eff[HEAVE] - eff[PITCH] - eff[ROLL];
        raw[HBL] = rot_a - eff[YAW];
        raw[HBR] = rot_b + eff[YAW];
        raw[VBL] = eff[HEAVE] + eff[PITCH] + eff[ROLL];
        raw[VBR] = eff[HEAVE] + eff[PITCH] - eff[ROLL];
        peak = 0;
        for (int i = 0; i < NUM_LANES; i++)
            if (raw[i] > peak) peak = raw[i];
        cmds = '0;
        // no positive lane leaves every command at zero
        if (peak > 0) begin
            for (int i = 0; i < NUM_LANES; i++) begin
                q = round_div(raw[i] * (longint'(1) << FRAC_BITS), peak);
                if (q > FIELD_MAX) q = FIELD_MAX;
                if (q < FIELD_MIN) q = FIELD_MIN;
                cmds[i*W +: W] = q[W-1:0];
            end
        end
        return cmds;
    endfunction

    function automatic logic [IN_BITS-1:0] pack_efforts(input longint surge, input longint sway,
                                                       input longint heave, input longint roll,
                                                       input longint pitch, input longint yaw);
        logic [IN_BITS-1:0] word;
        word = '0;
        word[SURGE*W +: W] = surge[W-1:0];
        word[SWAY*W +: W]  = sway[W-1:0];
        word[HEAVE*W +: W] = heave[W-1:0];
        word[ROLL*W +: W]  = roll[W-1:0];
        word[PITCH*W +: W] = pitch[W-1:0];
        word[YAW*W +: W]   = yaw[W-1:0];
        return word;
    endfunction

    function automatic logic [IN_BITS-1:0] random_efforts();
        logic [IN_BITS-1:0] word;
        longint v;
        int style;
        word = '0;
        style = $urandom_range(0, 9);
        if (style == 8) begin
            // all lanes at or below zero: negative surge and heave only
            word = pack_efforts(-longint'($urandom_range(0, 32768)), 0,
                                -longint'($urandom_range(0, 32768)), 0, 0, 0);
        end else begin
            for (int i = 0; i < NUM_EFFORTS; i++) begin
                if (style <= 3)
                    v = longint'($urandom_range(0, 65535)) - 32768;
                else if (style <= 7)
                    v = longint'($urandom_range(0, 4095)) - 2048;
                else
                    v = longint'($urandom_range(0, 15)) - 8;
                word[i*W +: W] = v[W-1:0];
            end
        end
        return word;
    endfunction

    task automatic send_efforts(input logic [IN_BITS-1:0] word);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_tvalid = 1'b0;
            @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tdata = word;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        expected_cmds.push_back(mix_commands(word));
        sent_count++;
        @(negedge clk);
    endtask

    task automatic wait_for_drain();
        s_tvalid = 1'b0;
        while (expected_cmds.size() != 0) @(negedge clk);
    endtask

    task automatic test_extremes();
        send_efforts(pack_efforts(0, 0, 0, 0, 0, 0));
        send_efforts(pack_efforts(FIELD_MAX, FIELD_MAX, FIELD_MAX, FIELD_MAX, FIELD_MAX, FIELD_MAX));
        send_efforts(pack_efforts(FIELD_MIN, FIELD_MIN, FIELD_MIN, FIELD_MIN, FIELD_MIN, FIELD_MIN));
        // one axis alone at each end of its range
        for (int i = 0; i < NUM_EFFORTS; i++) begin
            logic [IN_BITS-1:0] word;
            word = '0;
            word[i*W +: W] = FIELD_MAX[W-1:0];
            send_efforts(word);
            word[i*W +: W] = FIELD_MIN[W-1:0];
            send_efforts(word);
        end
    endtask

    task automatic test_no_positive_peak();
        send_efforts(pack_efforts(0, 0, -1000, 0, 0, 0));
        send_efforts(pack_efforts(-5000, 0, 0, 0, 0, 0));
        send_efforts(pack_efforts(FIELD_MIN, 0, FIELD_MIN, 0, 0, 0));
    endtask

    task automatic test_saturation();
        // horizontal lanes far below a tiny vertical peak
        send_efforts(pack_efforts(FIELD_MIN, 0, 1, 0, 0, 0));
        // horizontal lanes land exactly on -8.0, then just past it
        send_efforts(pack_efforts(-11, 0, 0, 1, 0, 0));
        send_efforts(pack_efforts(-13, 0, 0, 1, 0, 0));
        // half-lsb quotients round away from zero, then a word with exact quotients
        send_efforts(pack_efforts(0, 0, 0, 8192, 0, 1));
        send_efforts(pack_efforts(0, 0, 0, 2, 0, 1));
    endtask

    task automatic test_random_traffic(input int count, input int src_pct, input int snk_pct);
        src_idle_pct = src_pct;
        snk_idle_pct = snk_pct;
        repeat (count) send_efforts(random_efforts());
    endtask

    always @(negedge clk) begin
        m_tready <= ($urandom_range(0, 99) >= snk_idle_pct);
    end

    always @(posedge clk) begin : result_check
        logic [OUT_BITS-1:0] want;
        if (rst_n && m_tvalid && m_tready) begin
            recv_count++;
            if (expected_cmds.size() == 0) begin
                $display("%0t: unexpected command word %h", $time, m_tdata);
                mismatch_count++;
            end else begin
                want = expected_cmds.pop_front();
                for (int i = 0; i < NUM_LANES; i++) begin
                    if (m_tdata[i*W +: W] !== want[i*W +: W]) begin
                        $display("%0t: lane %s expected %0d actual %0d", $time, lane_names[i],
                                 $signed(want[i*W +: W]), $signed(m_tdata[i*W +: W]));
                        mismatch_count++;
                    end
                end
            end
        end
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d words still expected", cycle_count,
                     expected_cmds.size());
            $display("FAILED: results differ");
            $finish;
        end
    end

    initial begin
        repeat (12) @(negedge clk);
        rst_n = 1'b1;
        test_extremes();
        test_no_positive_peak();
        test_saturation();
        // hold the sender back until the pipe is empty
        wait_for_drain();
        test_random_traffic(650, 16, 60);
        test_random_traffic(650, 60, 16);
        test_random_traffic(650, 0, 0);
        wait_for_drain();
        repeat (2 * LATENCY) @(negedge clk);
        $display("sent %0d effort words and checked %0d command words under three stall mixes,",
                 sent_count, recv_count);
        $display("including range extremes, zero peak and saturating quotients");
        if (mismatch_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
